[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the circle intersection core.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define CCI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CCI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/cci_pkg.sv]
// Package of the circle intersection core: widths, field and pipeline types.
// Depends on nothing; used by the channel interfaces and the core.
`timescale 1ns / 1ps
`default_nettype none

package cci_pkg;

   localparam int COORD_WIDTH = 20;
   localparam int SQ_W   = 2 * COORD_WIDTH;
   localparam int S_W    = 2 * COORD_WIDTH + 1;
   localparam int T_W    = 4 * COORD_WIDTH;
   localparam int RW     = T_W + 2;
   localparam int H_W    = 2 * COORD_WIDTH;
   localparam int TM_W   = 3 * COORD_WIDTH;
   localparam int NUM_W  = 3 * COORD_WIDTH + 2;
   localparam int Q_W    = COORD_WIDTH + 1;
   localparam int PTS    = 4;
   localparam int NPART  = 8;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type               c1x;
      coord_type               c1y;
      logic [COORD_WIDTH-1:0]  am;
      logic [COORD_WIDTH-1:0]  bm;
      logic                    an;
      logic                    bn;
      logic                    sn;
      logic                    dn;
      logic [SQ_W-1:0]         dm;
      logic [SQ_W-1:0]         s;
      logic                    found;
   } carry_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [Q_W-1:0]   q;
      logic             big;
      logic             neg;
   } quo_type;

   typedef struct packed {
      logic      found;
      coord_type point_a_x;
      coord_type point_a_y;
      coord_type point_b_x;
      coord_type point_b_y;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/cci_if.sv]
// Valid/ready channel interfaces for the circle intersection core.
// Depends on cci_pkg for the coordinate type.
`timescale 1ns / 1ps
`default_nettype none

interface cci_req_if import cci_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type first_center_x;
   coord_type first_center_y;
   coord_type first_radius;
   coord_type second_center_x;
   coord_type second_center_y;
   coord_type second_radius;

   modport source (output valid, first_center_x, first_center_y, first_radius,
                   second_center_x, second_center_y, second_radius, input ready);
   modport sink   (input valid, first_center_x, first_center_y, first_radius,
                   second_center_x, second_center_y, second_radius, output ready);
endinterface

interface cci_rsp_if import cci_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      found;
   coord_type point_a_x;
   coord_type point_a_y;
   coord_type point_b_x;
   coord_type point_b_y;

   modport source (output valid, found, point_a_x, point_a_y, point_b_x, point_b_y,
                   input ready);
   modport sink   (input valid, found, point_a_x, point_a_y, point_b_x, point_b_y,
                   output ready);
endinterface

`default_nettype wire

[hdl/circle_circle_intersection_core.sv]
// Circle intersection core: takes a pair of circles per request beat and returns
// whether they meet and both crossing points in Q11.8. Depends on cci_pkg, cci_if
// and assert_macros.svh.
//
// One pair enters per clock while the skid entry is empty, and each result passes through
// seven setup stages of squares and tests, a square root that settles one root bit per
// stage, five product and sum stages, and a restoring divider that settles one quotient
// bit per stage. The whole pipeline moves together; a two-entry output register absorbs
// a stalled response so that request beats keep flowing until both entries hold a result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module circle_circle_intersection_core import cci_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cci_req_if.sink   req_chan,
   cci_rsp_if.source rsp_chan
);

   localparam int CW = COORD_WIDTH;
   localparam logic [Q_W-1:0] Q_LIMIT = {1'b1, {CW{1'b0}}};
   localparam logic signed [CW+1:0] V_MAX = {3'b000, {(CW-1){1'b1}}};
   localparam logic signed [CW+1:0] V_MIN = {3'b111, {(CW-1){1'b0}}};

   function automatic coord_type place(coord_type base, logic neg, logic big,
                                       logic [Q_W-1:0] q);
      logic [Q_W-1:0]         qc;
      logic signed [CW+1:0]   bx;
      logic signed [CW+1:0]   qx;
      logic signed [CW+1:0]   v;
      qc = (big || q > Q_LIMIT) ? Q_LIMIT : q;
      bx = $signed({{2{base[CW-1]}}, base});
      qx = $signed({1'b0, qc});
      v  = neg ? bx - qx : bx + qx;
      if (v > V_MAX) begin
         v = V_MAX;
      end else if (v < V_MIN) begin
         v = V_MIN;
      end
      return v[CW-1:0];
   endfunction

   logic adv;
   logic skid_valid_ff, skid_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign adv = !skid_valid_ff;
   assign req_chan.ready = adv;

   // Stage 1: centre offset, magnitudes and the trivial rejections.
   logic signed [CW:0] dx, dy;
   logic [CW:0] adx, ady;
   logic r1pos, r2pos;
   carry_type car1_in, car1_ff;
   logic [CW-2:0] r1_1_in, r1_1_ff, r2_1_in, r2_1_ff;
   logic v1_ff, v1_in;

   always_comb begin
      dx = $signed({req_chan.second_center_x[CW-1], req_chan.second_center_x})
         - $signed({req_chan.first_center_x[CW-1], req_chan.first_center_x});
      dy = $signed({req_chan.second_center_y[CW-1], req_chan.second_center_y})
         - $signed({req_chan.first_center_y[CW-1], req_chan.first_center_y});
      adx = dx[CW] ? -dx : dx;
      ady = dy[CW] ? -dy : dy;
      r1pos = !req_chan.first_radius[CW-1] && (req_chan.first_radius != '0);
      r2pos = !req_chan.second_radius[CW-1] && (req_chan.second_radius != '0);
      car1_in.c1x   = req_chan.first_center_x;
      car1_in.c1y   = req_chan.first_center_y;
      car1_in.am    = adx[CW-1:0];
      car1_in.bm    = ady[CW-1:0];
      car1_in.an    = dx[CW];
      car1_in.bn    = dy[CW];
      car1_in.sn    = (dx != '0) ? dx[CW] : !dy[CW];
      car1_in.dn    = 1'b0;
      car1_in.dm    = '0;
      car1_in.s     = '0;
      car1_in.found = r1pos && r2pos && (dx != '0 || dy != '0);
      r1_1_in = req_chan.first_radius[CW-2:0];
      r2_1_in = req_chan.second_radius[CW-2:0];
      v1_in   = req_chan.valid;
   end

   // Stage 2: squares.
   carry_type car2_ff;
   logic [SQ_W-1:0] amsq2_ff, amsq2_in, bmsq2_ff, bmsq2_in;
   logic [SQ_W-1:0] rsumsq2_ff, rsumsq2_in, rdifsq2_ff, rdifsq2_in;
   logic [SQ_W-1:0] r1sq2_ff, r1sq2_in, r2sq2_ff, r2sq2_in;
   logic [CW-1:0] rsum;
   logic [CW-2:0] rdif;
   logic v2_ff;

   always_comb begin
      rsum = CW'(r1_1_ff) + CW'(r2_1_ff);
      rdif = (r1_1_ff >= r2_1_ff) ? r1_1_ff - r2_1_ff : r2_1_ff - r1_1_ff;
      amsq2_in   = SQ_W'(car1_ff.am) * SQ_W'(car1_ff.am);
      bmsq2_in   = SQ_W'(car1_ff.bm) * SQ_W'(car1_ff.bm);
      rsumsq2_in = SQ_W'(rsum) * SQ_W'(rsum);
      rdifsq2_in = SQ_W'(rdif) * SQ_W'(rdif);
      r1sq2_in   = SQ_W'(r1_1_ff) * SQ_W'(r1_1_ff);
      r2sq2_in   = SQ_W'(r2_1_ff) * SQ_W'(r2_1_ff);
   end

   // Stage 3: squared distance and difference of the squared radii.
   carry_type car3_ff;
   logic [S_W-1:0] s3_ff, s3_in;
   logic signed [SQ_W-2:0] rd3_ff, rd3_in;
   logic [SQ_W-1:0] rsumsq3_ff, rdifsq3_ff, r1sq3_ff;
   logic v3_ff;

   always_comb begin
      s3_in  = S_W'(amsq2_ff) + S_W'(bmsq2_ff);
      rd3_in = $signed(r1sq2_ff[SQ_W-2:0]) - $signed(r2sq2_ff[SQ_W-2:0]);
   end

   // Stage 4: reach tests and the signed Dq term.
   carry_type car4_ff, car4_in;
   logic signed [SQ_W+1:0] dq4_ff, dq4_in;
   logic [SQ_W-1:0] r1sq4_ff;
   logic v4_ff;

   always_comb begin
      car4_in = car3_ff;
      car4_in.s = s3_ff[SQ_W-1:0];
      car4_in.found = car3_ff.found && !(s3_ff > S_W'(rsumsq3_ff))
                      && !(s3_ff < S_W'(rdifsq3_ff));
      dq4_in = $signed({1'b0, s3_ff}) + $signed({{3{rd3_ff[SQ_W-2]}}, rd3_ff});
   end

   // Stage 5: |Dq| and partial products of S*r1^2.
   carry_type car5_ff, car5_in;
   logic [SQ_W+1:0] dabs;
   logic [SQ_W-1:0] hp_hh5_ff, hp_hh5_in, hp_hl5_ff, hp_hl5_in;
   logic [SQ_W-1:0] hp_lh5_ff, hp_lh5_in, hp_ll5_ff, hp_ll5_in;
   logic v5_ff;

   always_comb begin
      dabs = dq4_ff[SQ_W+1] ? -dq4_ff : dq4_ff;
      car5_in = car4_ff;
      car5_in.dn = dq4_ff[SQ_W+1];
      car5_in.dm = dabs[SQ_W-1:0];
      hp_hh5_in = SQ_W'(car4_ff.s[SQ_W-1:CW]) * SQ_W'(r1sq4_ff[SQ_W-3:CW]);
      hp_hl5_in = SQ_W'(car4_ff.s[SQ_W-1:CW]) * SQ_W'(r1sq4_ff[CW-1:0]);
      hp_lh5_in = SQ_W'(car4_ff.s[CW-1:0]) * SQ_W'(r1sq4_ff[SQ_W-3:CW]);
      hp_ll5_in = SQ_W'(car4_ff.s[CW-1:0]) * SQ_W'(r1sq4_ff[CW-1:0]);
   end

   // Stage 6: 4*S*r1^2 and partial products of Dq^2.
   carry_type car6_ff;
   logic [T_W-1:0] hh6_ff, hh6_in;
   logic [SQ_W-1:0] dp_hh6_ff, dp_hh6_in, dp_hl6_ff, dp_hl6_in, dp_ll6_ff, dp_ll6_in;
   logic v6_ff;

   always_comb begin
      hh6_in = ((T_W'(hp_hh5_ff) << (2 * CW)) + (T_W'(hp_hl5_ff) << CW)
               + (T_W'(hp_lh5_ff) << CW) + T_W'(hp_ll5_ff)) << 2;
      dp_hh6_in = SQ_W'(car5_ff.dm[SQ_W-1:CW]) * SQ_W'(car5_ff.dm[SQ_W-1:CW]);
      dp_hl6_in = SQ_W'(car5_ff.dm[SQ_W-1:CW]) * SQ_W'(car5_ff.dm[CW-1:0]);
      dp_ll6_in = SQ_W'(car5_ff.dm[CW-1:0]) * SQ_W'(car5_ff.dm[CW-1:0]);
   end

   // Stage 7: Dq^2.
   carry_type car7_ff;
   logic [T_W-1:0] hh7_ff, dd7_ff, dd7_in;
   logic v7_ff;

   assign dd7_in = (T_W'(dp_hh6_ff) << (2 * CW)) + (T_W'(dp_hl6_ff) << (CW + 1))
                 + T_W'(dp_ll6_ff);

   // Square root, one root bit per stage; entry zero holds the clamped radicand.
   logic [T_W-1:0]  sq_rem_ff  [H_W+1];
   logic [T_W-1:0]  sq_rem_in  [H_W+1];
   logic [H_W-1:0]  sq_root_ff [H_W+1];
   logic [H_W-1:0]  sq_root_in [H_W+1];
   carry_type       sq_car_ff  [H_W+1];
   logic            sq_v_ff    [H_W+1];
   logic [RW-1:0]   sq_trial   [H_W+1];
   logic            sq_ge      [H_W+1];

   assign sq_trial[0]   = '0;
   assign sq_ge[0]      = 1'b0;
   assign sq_rem_in[0]  = (hh7_ff >= dd7_ff) ? hh7_ff - dd7_ff : '0;
   assign sq_root_in[0] = '0;

   for (genvar k = 1; k <= H_W; k++) begin : g_sqrt
      localparam int BIT = H_W - k;
      assign sq_trial[k] = (RW'(sq_root_ff[k-1]) << (BIT + 1)) | (RW'(1) << (2 * BIT));
      assign sq_ge[k] = RW'(sq_rem_ff[k-1]) >= sq_trial[k];
      assign sq_rem_in[k] = sq_ge[k] ? sq_rem_ff[k-1] - sq_trial[k][T_W-1:0]
                                     : sq_rem_ff[k-1];
      assign sq_root_in[k] = sq_root_ff[k-1] | (H_W'(sq_ge[k]) << BIT);
   end

   // Product stages.
   logic [SQ_W-1:0] p1_pp_ff [NPART];
   logic [SQ_W-1:0] p1_pp_in [NPART];
   logic [TM_W-1:0] p2_t_ff [PTS];
   logic [TM_W-1:0] p2_t_in [PTS];
   logic signed [NUM_W-1:0] p3_st_ff [PTS];
   logic signed [NUM_W-1:0] p3_st_in [PTS];
   logic signed [NUM_W-1:0] n_num_ff [PTS];
   logic signed [NUM_W-1:0] n_num_in [PTS];
   logic [NUM_W-1:0] m_mag_ff [PTS];
   logic [NUM_W-1:0] m_mag_in [PTS];
   logic m_neg_ff [PTS];
   logic [PTS-1:0] p3_sg;
   carry_type p1_car_ff, p2_car_ff, p3_car_ff, n_car_ff, m_car_ff;
   logic p1_v_ff, p2_v_ff, p3_v_ff, n_v_ff, m_v_ff;
   logic [H_W-1:0] h_root;

   always_comb begin
      h_root = sq_root_ff[H_W];
      p1_pp_in[0] = SQ_W'(sq_car_ff[H_W].am) * SQ_W'(sq_car_ff[H_W].dm[SQ_W-1:CW]);
      p1_pp_in[1] = SQ_W'(sq_car_ff[H_W].am) * SQ_W'(sq_car_ff[H_W].dm[CW-1:0]);
      p1_pp_in[2] = SQ_W'(sq_car_ff[H_W].bm) * SQ_W'(sq_car_ff[H_W].dm[SQ_W-1:CW]);
      p1_pp_in[3] = SQ_W'(sq_car_ff[H_W].bm) * SQ_W'(sq_car_ff[H_W].dm[CW-1:0]);
      p1_pp_in[4] = SQ_W'(sq_car_ff[H_W].am) * SQ_W'(h_root[H_W-1:CW]);
      p1_pp_in[5] = SQ_W'(sq_car_ff[H_W].am) * SQ_W'(h_root[CW-1:0]);
      p1_pp_in[6] = SQ_W'(sq_car_ff[H_W].bm) * SQ_W'(h_root[H_W-1:CW]);
      p1_pp_in[7] = SQ_W'(sq_car_ff[H_W].bm) * SQ_W'(h_root[CW-1:0]);
      for (int j = 0; j < PTS; j++) begin
         p2_t_in[j] = (TM_W'(p1_pp_ff[2*j]) << CW) + TM_W'(p1_pp_ff[2*j+1]);
      end
      p3_sg[0] = p2_car_ff.an ^ p2_car_ff.dn;
      p3_sg[1] = p2_car_ff.bn ^ p2_car_ff.dn;
      p3_sg[2] = p2_car_ff.an ^ p2_car_ff.sn;
      p3_sg[3] = p2_car_ff.bn ^ p2_car_ff.sn;
      for (int j = 0; j < PTS; j++) begin
         p3_st_in[j] = p3_sg[j] ? -$signed(NUM_W'(p2_t_ff[j])) : $signed(NUM_W'(p2_t_ff[j]));
      end
      n_num_in[0] = p3_st_ff[0] - p3_st_ff[3];
      n_num_in[1] = p3_st_ff[1] + p3_st_ff[2];
      n_num_in[2] = p3_st_ff[0] + p3_st_ff[3];
      n_num_in[3] = p3_st_ff[1] - p3_st_ff[2];
      for (int j = 0; j < PTS; j++) begin
         m_mag_in[j] = n_num_ff[j][NUM_W-1] ? -n_num_ff[j] : n_num_ff[j];
      end
   end

   // Restoring division by 2*S, one quotient bit per stage; entry zero flags overflow.
   quo_type   dv_quo_ff [Q_W+1][PTS];
   quo_type   dv_quo_in [Q_W+1][PTS];
   carry_type dv_car_ff [Q_W+1];
   logic      dv_v_ff   [Q_W+1];

   for (genvar j = 0; j < PTS; j++) begin : g_div0
      assign dv_quo_in[0][j].rem = m_mag_ff[j];
      assign dv_quo_in[0][j].q   = '0;
      assign dv_quo_in[0][j].neg = m_neg_ff[j];
      assign dv_quo_in[0][j].big = m_mag_ff[j] >= (NUM_W'({m_car_ff.s, 1'b0}) << Q_W);
   end

   for (genvar k = 1; k <= Q_W; k++) begin : g_div
      localparam int BIT = Q_W - k;
      logic [NUM_W-1:0] dsh;
      assign dsh = NUM_W'({dv_car_ff[k-1].s, 1'b0}) << BIT;
      for (genvar j = 0; j < PTS; j++) begin : g_pt
         logic ge;
         assign ge = dv_quo_ff[k-1][j].rem >= dsh;
         assign dv_quo_in[k][j].rem = ge ? dv_quo_ff[k-1][j].rem - dsh
                                         : dv_quo_ff[k-1][j].rem;
         assign dv_quo_in[k][j].q   = dv_quo_ff[k-1][j].q | (Q_W'(ge) << BIT);
         assign dv_quo_in[k][j].big = dv_quo_ff[k-1][j].big;
         assign dv_quo_in[k][j].neg = dv_quo_ff[k-1][j].neg;
      end
   end

   // Final placement and saturation.
   rsp_type pipe_rsp;
   logic pipe_v;
   carry_type last_car;

   always_comb begin
      last_car = dv_car_ff[Q_W];
      pipe_v   = dv_v_ff[Q_W];
      pipe_rsp.found = last_car.found;
      pipe_rsp.point_a_x = '0;
      pipe_rsp.point_a_y = '0;
      pipe_rsp.point_b_x = '0;
      pipe_rsp.point_b_y = '0;
      if (last_car.found) begin
         pipe_rsp.point_a_x = place(last_car.c1x, dv_quo_ff[Q_W][0].neg,
                                    dv_quo_ff[Q_W][0].big, dv_quo_ff[Q_W][0].q);
         pipe_rsp.point_a_y = place(last_car.c1y, dv_quo_ff[Q_W][1].neg,
                                    dv_quo_ff[Q_W][1].big, dv_quo_ff[Q_W][1].q);
         pipe_rsp.point_b_x = place(last_car.c1x, dv_quo_ff[Q_W][2].neg,
                                    dv_quo_ff[Q_W][2].big, dv_quo_ff[Q_W][2].q);
         pipe_rsp.point_b_y = place(last_car.c1y, dv_quo_ff[Q_W][3].neg,
                                    dv_quo_ff[Q_W][3].big, dv_quo_ff[Q_W][3].q);
      end
   end

   // Output register with a skid entry behind it.
   logic rsp_take;
   assign rsp_take = rsp_valid_ff && rsp_chan.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (pipe_v) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = pipe_rsp;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = pipe_rsp;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.found     = rsp_data_ff.found;
   assign rsp_chan.point_a_x = rsp_data_ff.point_a_x;
   assign rsp_chan.point_a_y = rsp_data_ff.point_a_y;
   assign rsp_chan.point_b_x = rsp_data_ff.point_b_x;
   assign rsp_chan.point_b_y = rsp_data_ff.point_b_y;

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         for (int k = 0; k <= H_W; k++) begin
            sq_v_ff[k] <= 1'b0;
         end
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         n_v_ff  <= 1'b0;
         m_v_ff  <= 1'b0;
         for (int k = 0; k <= Q_W; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            v1_ff <= v1_in;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
            v5_ff <= v4_ff;
            v6_ff <= v5_ff;
            v7_ff <= v6_ff;
            sq_v_ff[0] <= v7_ff;
            for (int k = 1; k <= H_W; k++) begin
               sq_v_ff[k] <= sq_v_ff[k-1];
            end
            p1_v_ff <= sq_v_ff[H_W];
            p2_v_ff <= p1_v_ff;
            p3_v_ff <= p2_v_ff;
            n_v_ff  <= p3_v_ff;
            m_v_ff  <= n_v_ff;
            dv_v_ff[0] <= m_v_ff;
            for (int k = 1; k <= Q_W; k++) begin
               dv_v_ff[k] <= dv_v_ff[k-1];
            end
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         car1_ff    <= car1_in;
         r1_1_ff    <= r1_1_in;
         r2_1_ff    <= r2_1_in;
         car2_ff    <= car1_ff;
         amsq2_ff   <= amsq2_in;
         bmsq2_ff   <= bmsq2_in;
         rsumsq2_ff <= rsumsq2_in;
         rdifsq2_ff <= rdifsq2_in;
         r1sq2_ff   <= r1sq2_in;
         r2sq2_ff   <= r2sq2_in;
         car3_ff    <= car2_ff;
         s3_ff      <= s3_in;
         rd3_ff     <= rd3_in;
         rsumsq3_ff <= rsumsq2_ff;
         rdifsq3_ff <= rdifsq2_ff;
         r1sq3_ff   <= r1sq2_ff;
         car4_ff    <= car4_in;
         dq4_ff     <= dq4_in;
         r1sq4_ff   <= r1sq3_ff;
         car5_ff    <= car5_in;
         hp_hh5_ff  <= hp_hh5_in;
         hp_hl5_ff  <= hp_hl5_in;
         hp_lh5_ff  <= hp_lh5_in;
         hp_ll5_ff  <= hp_ll5_in;
         car6_ff    <= car5_ff;
         hh6_ff     <= hh6_in;
         dp_hh6_ff  <= dp_hh6_in;
         dp_hl6_ff  <= dp_hl6_in;
         dp_ll6_ff  <= dp_ll6_in;
         car7_ff    <= car6_ff;
         hh7_ff     <= hh6_ff;
         dd7_ff     <= dd7_in;
         sq_car_ff[0] <= car7_ff;
         for (int k = 0; k <= H_W; k++) begin
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
         end
         for (int k = 1; k <= H_W; k++) begin
            sq_car_ff[k] <= sq_car_ff[k-1];
         end
         p1_car_ff <= sq_car_ff[H_W];
         p2_car_ff <= p1_car_ff;
         p3_car_ff <= p2_car_ff;
         n_car_ff  <= p3_car_ff;
         m_car_ff  <= n_car_ff;
         for (int j = 0; j < NPART; j++) begin
            p1_pp_ff[j] <= p1_pp_in[j];
         end
         for (int j = 0; j < PTS; j++) begin
            p2_t_ff[j]  <= p2_t_in[j];
            p3_st_ff[j] <= p3_st_in[j];
            n_num_ff[j] <= n_num_in[j];
            m_mag_ff[j] <= m_mag_in[j];
            m_neg_ff[j] <= n_num_ff[j][NUM_W-1];
         end
         dv_car_ff[0] <= m_car_ff;
         for (int k = 1; k <= Q_W; k++) begin
            dv_car_ff[k] <= dv_car_ff[k-1];
         end
         for (int k = 0; k <= Q_W; k++) begin
            for (int j = 0; j < PTS; j++) begin
               dv_quo_ff[k][j] <= dv_quo_in[k][j];
            end
         end
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   `CCI_ASSERT_ALWAYS(a_skid_behind_out, clock,
      skid_valid_ff |-> rsp_valid_ff, "skid entry holds a beat while the output is empty")
   `CCI_ASSERT(a_skid_fill, clock, reset,
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_chan.ready),
      "skid entry filled although the output beat could leave")
   `CCI_ASSERT(a_miss_zero, clock, reset,
      (rsp_chan.valid && !rsp_chan.found) |-> (rsp_chan.point_a_x == '0 &&
      rsp_chan.point_a_y == '0 && rsp_chan.point_b_x == '0 && rsp_chan.point_b_y == '0),
      "result without intersection carries nonzero points")

endmodule

`default_nettype wire
